FILE: rtl/core/bbd_pkg.sv
// Blink beacon detector package: word types, phase codes, register indexes.
// Used by bbd_step and blink_beacon_detector. No dependencies.
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int TIME_BITS   = 32;
  localparam int PERIOD_BITS = 24;
  localparam int ATT_BITS    = 3;
  localparam int TOUT_BITS   = 32;
  localparam int CFG_BITS    = 32;
  localparam int IDX_BITS    = 2;

  // compare widths wide enough for both operands
  localparam int WIN_BITS  = (TIME_BITS > PERIOD_BITS + 1) ? TIME_BITS : PERIOD_BITS + 1;
  localparam int FAIL_BITS = (TIME_BITS > TOUT_BITS) ? TIME_BITS : TOUT_BITS;

  localparam logic [ATT_BITS-1:0] ATT_MAX = '1;

  localparam logic [IDX_BITS-1:0] REG_EDGE_PERIOD  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_BLINK_MARGIN = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MAX_ATTEMPTS = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_FAIL_TIMEOUT = 2'd3;

  localparam logic [PERIOD_BITS-1:0] RST_EDGE_PERIOD  = 24'd250000;
  localparam logic [PERIOD_BITS-1:0] RST_BLINK_MARGIN = 24'd187500;
  localparam logic [ATT_BITS-1:0]    RST_MAX_ATTEMPTS = 3'd4;
  localparam logic [TOUT_BITS-1:0]   RST_FAIL_TIMEOUT = 32'd2000000;

  typedef enum logic [4:0] {
    PH_START    = 5'd0,
    PH_RESTART  = 5'd1,
    PH_SEARCH   = 5'd2,
    PH_B1_OFF   = 5'd3,
    PH_B1_ON    = 5'd4,
    PH_B2_OFF   = 5'd5,
    PH_B2_ON    = 5'd6,
    PH_B3_OFF   = 5'd7,
    PH_B3_ON    = 5'd8,
    PH_B4_OFF   = 5'd9,
    PH_B4_ON    = 5'd10,
    PH_B5_OFF   = 5'd11,
    PH_B5_ON    = 5'd12,
    PH_B6_CALIB = 5'd13,
    PH_B6_OFF   = 5'd14,
    PH_B6_ON    = 5'd15,
    PH_FOUND    = 5'd16,
    PH_FAILED   = 5'd17,
    PH_DELETE   = 5'd18
  } phase_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] frame_time;
    logic                 item_seen;
    logic                 item_absent;
  } in_word_t;

  typedef struct packed {
    logic [4:0]          phase;
    logic                beacon_found;
    logic                search_failed;
    logic                delete_request;
    logic                raise_threshold;
    logic [ATT_BITS-1:0] attempt_count;
  } out_word_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] edge_period;
    logic [PERIOD_BITS-1:0] blink_margin;
    logic [ATT_BITS-1:0]    max_attempts;
    logic [TOUT_BITS-1:0]   fail_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [ATT_BITS-1:0]  attempts;
    logic [TIME_BITS-1:0] edge_start;
    logic [TIME_BITS-1:0] fail_start;
  } state_t;

endpackage

FILE: rtl/core/bbd_step.sv
// Next-state and result logic for one frame word of the beacon detector.
// Purely combinational; depends on bbd_pkg.
`timescale 1ns / 1ps

module bbd_step (
  input  bbd_pkg::state_t    st,
  input  bbd_pkg::cfg_t      cfg,
  input  bbd_pkg::in_word_t  item,
  output bbd_pkg::state_t    st_next,
  output bbd_pkg::out_word_t result
);

  logic [bbd_pkg::TIME_BITS-1:0] edge_elapsed;
  logic [bbd_pkg::TIME_BITS-1:0] fail_elapsed;
  logic [bbd_pkg::WIN_BITS-1:0]  win_elapsed;
  logic [bbd_pkg::WIN_BITS-1:0]  win_hi;
  logic [bbd_pkg::WIN_BITS-1:0]  win_lo;
  logic                          above;
  logic                          below_hi;
  logic                          past_hi;
  logic                          timed_out;
  logic [bbd_pkg::ATT_BITS-1:0]  att_inc;
  bbd_pkg::phase_t               chk_ph;
  logic                          is_off;
  logic                          flag;
  logic                          raise;

  assign edge_elapsed = item.frame_time - st.edge_start;
  assign fail_elapsed = item.frame_time - st.fail_start;
  assign win_elapsed  = bbd_pkg::WIN_BITS'(edge_elapsed);
  assign win_hi = bbd_pkg::WIN_BITS'(cfg.edge_period) + bbd_pkg::WIN_BITS'(cfg.blink_margin);
  assign win_lo = bbd_pkg::WIN_BITS'(cfg.edge_period - cfg.blink_margin);

  // margin above period leaves no lower limit
  assign above     = (cfg.blink_margin > cfg.edge_period) || (win_elapsed > win_lo);
  assign below_hi  = win_elapsed < win_hi;
  assign past_hi   = win_elapsed > win_hi;
  assign timed_out = bbd_pkg::FAIL_BITS'(fail_elapsed) > bbd_pkg::FAIL_BITS'(cfg.fail_timeout);

  // calib phase is checked as 6 off
  assign chk_ph = (st.phase == bbd_pkg::PH_B6_CALIB) ? bbd_pkg::PH_B6_OFF : st.phase;
  assign is_off = (chk_ph == bbd_pkg::PH_B6_OFF) ||
                  ((chk_ph < bbd_pkg::PH_B6_CALIB) && chk_ph[0]);
  assign flag   = is_off ? item.item_absent : item.item_seen;

  always_comb begin
    st_next = st;
    raise   = 1'b0;
    att_inc = st.attempts;
    unique case (st.phase) inside
      bbd_pkg::PH_START, bbd_pkg::PH_RESTART, bbd_pkg::PH_SEARCH: begin
        if (st.phase != bbd_pkg::PH_SEARCH && st.attempts != bbd_pkg::ATT_MAX) begin
          att_inc = st.attempts + 1'b1;
        end
        st_next.attempts = att_inc;
        st_next.phase    = bbd_pkg::PH_SEARCH;
        if (att_inc > cfg.max_attempts) begin
          st_next.phase      = bbd_pkg::PH_FAILED;
          st_next.fail_start = item.frame_time;
        end
        if (item.item_seen) begin
          st_next.phase      = bbd_pkg::PH_B1_OFF;
          st_next.edge_start = item.frame_time;
          raise              = 1'b1;
        end
      end
      [bbd_pkg::PH_B1_OFF:bbd_pkg::PH_B6_ON]: begin
        if (st.phase == bbd_pkg::PH_B4_OFF) begin
          st_next.attempts = '0;
        end
        st_next.phase = chk_ph;
        if (flag) begin
          if (above && below_hi) begin
            st_next.phase      = bbd_pkg::phase_t'(5'(chk_ph) + 5'd1);
            st_next.edge_start = item.frame_time;
          end else begin
            st_next.phase = bbd_pkg::PH_RESTART;
          end
        end else if (past_hi) begin
          st_next.phase = bbd_pkg::PH_RESTART;
        end
      end
      bbd_pkg::PH_FAILED: begin
        if (timed_out) begin
          st_next.phase = bbd_pkg::PH_DELETE;
        end
      end
      default: begin
        // found and delete hold
      end
    endcase
  end

  always_comb begin
    result.phase           = 5'(st_next.phase);
    result.beacon_found    = (st_next.phase == bbd_pkg::PH_FOUND);
    result.search_failed   = (st_next.phase == bbd_pkg::PH_FAILED) ||
                             (st_next.phase == bbd_pkg::PH_DELETE);
    result.delete_request  = (st_next.phase == bbd_pkg::PH_DELETE);
    result.raise_threshold = raise;
    result.attempt_count   = st_next.attempts;
  end

endmodule

FILE: rtl/core/blink_beacon_detector.sv
// Blink beacon detector top level: input register, phase state, result register.
// Depends on bbd_pkg and bbd_step.
`timescale 1ns / 1ps

// Usage
//   item channel: one word per camera frame (frame time, seen and absent flags),
//   taken at a clock edge with item_valid high and item_stall low.
//   result channel: one word per frame word, in order, with the phase after
//   that frame, the found/failed/delete flags, the raise-threshold pulse and
//   the attempt count. Hold result_stall to keep the word; it does not change.
//   A word accepted into the input register is processed once the result word
//   is free or being taken, and is then held on the result port until taken.
//   Throughput: one word per cycle while result_stall is low, set by the phase
//   update that reads and writes the state registers for each word.
//   While result is stalled, one more word is taken into the input register;
//   item_stall then rises until the result word is taken.
//   Reset (rst, synchronous): phase start, attempt count and start times zero,
//   both channels empty, registers back to defaults (period 250000, margin
//   187500, attempts 4, timeout 2000000).
//   Configuration: cfg_we with cfg_index 0..3 writes period, margin, attempts,
//   timeout; write only while no word is in flight.

module blink_beacon_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  bbd_pkg::in_word_t                   item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bbd_pkg::out_word_t                  result,
  input  logic                                cfg_we,
  input  logic [bbd_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [bbd_pkg::CFG_BITS-1:0]        cfg_data
);

  logic               in_full;
  bbd_pkg::in_word_t  in_reg;
  logic               fire;
  logic               take;
  bbd_pkg::cfg_t      cfg;
  bbd_pkg::state_t    st;
  bbd_pkg::state_t    st_next;
  bbd_pkg::out_word_t result_next;

  assign fire       = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !fire;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_period  <= bbd_pkg::RST_EDGE_PERIOD;
      cfg.blink_margin <= bbd_pkg::RST_BLINK_MARGIN;
      cfg.max_attempts <= bbd_pkg::RST_MAX_ATTEMPTS;
      cfg.fail_timeout <= bbd_pkg::RST_FAIL_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbd_pkg::REG_EDGE_PERIOD:  cfg.edge_period  <= cfg_data[bbd_pkg::PERIOD_BITS-1:0];
        bbd_pkg::REG_BLINK_MARGIN: cfg.blink_margin <= cfg_data[bbd_pkg::PERIOD_BITS-1:0];
        bbd_pkg::REG_MAX_ATTEMPTS: cfg.max_attempts <= cfg_data[bbd_pkg::ATT_BITS-1:0];
        bbd_pkg::REG_FAIL_TIMEOUT: cfg.fail_timeout <= cfg_data[bbd_pkg::TOUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  bbd_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_reg),
    .st_next (st_next),
    .result  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= bbd_pkg::PH_START;
      st.attempts   <= '0;
      st.edge_start <= '0;
      st.fail_start <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  // found is terminal
  a_found_holds: assert property (@(posedge clk) disable iff (rst)
    st.phase == bbd_pkg::PH_FOUND |=> st.phase == bbd_pkg::PH_FOUND)
    else $error("found phase left");

  // a processed word always shows up on the result port
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed word without result");

  // state moves only when a word is processed
  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st.attempts) && $stable(st.phase))
    else $error("state changed without a word");

  // reported count matches the state just written
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    fire |=> result.attempt_count == st.attempts)
    else $error("attempt count out of step");

endmodule

FILE: tb/tb_blink_beacon_detector.sv
// Self-checking testbench for blink_beacon_detector: directed frame table, then shaped
// random and failure-path frames; a local phase predictor checks all but fixed rows. Needs bbd_pkg.
`timescale 1ns / 1ps

module tb_blink_beacon_detector;

  localparam int GEN_SHAPED = 0;
  localparam int GEN_FAIL   = 1;
  localparam int HOLD_OFF   = 300;

  typedef struct packed {
    bbd_pkg::in_word_t  word;
    logic               fixed_want;
    bbd_pkg::out_word_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  bbd_pkg::in_word_t            item;
  logic                         result_valid;
  logic                         result_stall;
  bbd_pkg::out_word_t           result;
  logic                         cfg_we;
  logic [bbd_pkg::IDX_BITS-1:0] cfg_index;
  logic [bbd_pkg::CFG_BITS-1:0] cfg_data;

  // predictor copy of the registers and the state
  logic [bbd_pkg::PERIOD_BITS-1:0] per_q;
  logic [bbd_pkg::PERIOD_BITS-1:0] mar_q;
  logic [bbd_pkg::ATT_BITS-1:0]    att_max_q;
  logic [bbd_pkg::TOUT_BITS-1:0]   tout_q;
  logic [4:0]                      ph_q;
  logic [bbd_pkg::ATT_BITS-1:0]    att_q;
  logic [bbd_pkg::TIME_BITS-1:0]   edge_q;
  logic [bbd_pkg::TIME_BITS-1:0]   fail_q;

  bbd_pkg::out_word_t due_words[$];
  int                 mismatches = 0;
  bit                 calm;
  bit                 hold_req;
  dir_row_t           dir_table [19];

  blink_beacon_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_blink_beacon_detector: FAIL");
    $finish;
  end

  function automatic logic [4:0] edge_step(logic [4:0] ph,
                                           logic [bbd_pkg::TIME_BITS-1:0] now,
                                           logic flag);
    logic [bbd_pkg::TIME_BITS-1:0] elapsed;
    logic [bbd_pkg::TIME_BITS:0]   hi;
    logic                          above;
    elapsed = now - edge_q;
    hi      = {9'd0, per_q} + {9'd0, mar_q};
    // margin above the period leaves no lower bound
    above   = (mar_q > per_q) || (elapsed > {8'd0, per_q - mar_q});
    if (flag) begin
      if (above && {1'b0, elapsed} < hi) begin
        edge_q = now;
        return ph + 5'd1;
      end
      return bbd_pkg::PH_RESTART;
    end
    if ({1'b0, elapsed} > hi) return bbd_pkg::PH_RESTART;
    return ph;
  endfunction

  function automatic bbd_pkg::out_word_t beacon_step(bbd_pkg::in_word_t w);
    logic [4:0]         ph;
    logic               raise;
    logic               is_off;
    bbd_pkg::out_word_t o;
    ph    = ph_q;
    raise = 1'b0;
    if (ph <= bbd_pkg::PH_SEARCH) begin
      if (ph != bbd_pkg::PH_SEARCH && att_q != bbd_pkg::ATT_MAX) att_q++;
      ph = bbd_pkg::PH_SEARCH;
      if (att_q > att_max_q) begin
        ph     = bbd_pkg::PH_FAILED;
        fail_q = w.frame_time;
      end
      if (w.item_seen) begin
        ph     = bbd_pkg::PH_B1_OFF;
        edge_q = w.frame_time;
        raise  = 1'b1;
      end
    end else if (ph <= bbd_pkg::PH_B6_ON) begin
      if (ph == bbd_pkg::PH_B4_OFF) att_q = '0;
      if (ph == bbd_pkg::PH_B6_CALIB) ph = bbd_pkg::PH_B6_OFF;
      is_off = (ph == bbd_pkg::PH_B6_OFF) || (ph < bbd_pkg::PH_B6_CALIB && ph[0]);
      ph = edge_step(ph, w.frame_time, is_off ? w.item_absent : w.item_seen);
    end else if (ph == bbd_pkg::PH_FAILED) begin
      if (w.frame_time - fail_q > tout_q) ph = bbd_pkg::PH_DELETE;
    end
    ph_q              = ph;
    o.phase           = ph;
    o.beacon_found    = (ph == bbd_pkg::PH_FOUND);
    o.search_failed   = (ph == bbd_pkg::PH_FAILED) || (ph == bbd_pkg::PH_DELETE);
    o.delete_request  = (ph == bbd_pkg::PH_DELETE);
    o.raise_threshold = raise;
    o.attempt_count   = att_q;
    return o;
  endfunction

  // Mostly frames that land inside the edge window for the awaited flag,
  // with holds, late edges and plain noise mixed in; fail mode gives noise only.
  function automatic bbd_pkg::in_word_t gen_item(int mode);
    bbd_pkg::in_word_t w;
    longint            lo;
    longint            hi;
    longint            e;
    logic              off_ph;
    logic              flag;
    int                r;
    w.frame_time  = $urandom;
    w.item_seen   = 1'($urandom);
    w.item_absent = 1'($urandom);
    r = $urandom_range(0, 99);
    if (mode == GEN_FAIL) begin
      w.item_seen = ($urandom_range(0, 3) == 0);
      return w;
    end
    lo = (mar_q > per_q) ? 0 : longint'(per_q) - longint'(mar_q) + 1;
    hi = longint'(per_q) + longint'(mar_q) - 1;
    if (r < 80 && ph_q <= bbd_pkg::PH_SEARCH) begin
      w.item_seen = ($urandom_range(0, 9) < 7);
    end else if (r < 80 && ph_q <= bbd_pkg::PH_B6_ON && lo <= hi) begin
      off_ph = (ph_q == bbd_pkg::PH_B6_CALIB) || (ph_q == bbd_pkg::PH_B6_OFF) ||
               (ph_q < bbd_pkg::PH_B6_CALIB && ph_q[0]);
      if (r < 68) begin
        e    = lo + longint'($urandom_range(32'(hi - lo), 0));
        flag = 1'b1;
      end else if (r < 76) begin
        e    = longint'($urandom_range(32'(hi + 1), 0));
        flag = 1'b0;
      end else begin
        e    = hi + 1 + longint'($urandom_range(3, 0));
        flag = 1'b1;
      end
      w.frame_time = edge_q + 32'(e);
      if (off_ph) w.item_absent = flag;
      else w.item_seen = flag;
    end
    // found is terminal and reset comes only once: always break the last edge late
    if (ph_q == bbd_pkg::PH_B6_ON) begin
      w.item_seen  = 1'b0;
      w.frame_time = edge_q + 32'(per_q) + 32'(mar_q) + 32'd1 + $urandom_range(1000, 0);
    end
    return w;
  endfunction

  function automatic dir_row_t row(logic [31:0] t, logic s, logic a, logic fixed = 1'b0,
                                   bbd_pkg::out_word_t want = '0);
    dir_row_t d;
    d.word       = '{t, s, a};
    d.fixed_want = fixed;
    d.want       = want;
    return d;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic check_word(bbd_pkg::out_word_t got);
    bbd_pkg::out_word_t want;
    if (due_words.size() == 0) begin
      flag_mismatch("result word with none due, phase", 32'd0, 32'(got.phase));
      return;
    end
    want = due_words.pop_front();
    if (got.phase !== want.phase)
      flag_mismatch("phase", 32'(want.phase), 32'(got.phase));
    if (got.beacon_found !== want.beacon_found)
      flag_mismatch("beacon_found", 32'(want.beacon_found), 32'(got.beacon_found));
    if (got.search_failed !== want.search_failed)
      flag_mismatch("search_failed", 32'(want.search_failed), 32'(got.search_failed));
    if (got.delete_request !== want.delete_request)
      flag_mismatch("delete_request", 32'(want.delete_request), 32'(got.delete_request));
    if (got.raise_threshold !== want.raise_threshold)
      flag_mismatch("raise_threshold", 32'(want.raise_threshold),
                    32'(got.raise_threshold));
    if (got.attempt_count !== want.attempt_count)
      flag_mismatch("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
  endtask

  task automatic send_word(bbd_pkg::in_word_t w, logic fixed = 1'b0,
                           bbd_pkg::out_word_t want = '0);
    bbd_pkg::out_word_t res;
    while (!calm && $urandom_range(0, 99) < 12) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && !item_stall));
    res = beacon_step(w);
    due_words.insert(due_words.size(), fixed ? want : res);
  endtask

  task automatic run_frames(int n, int mode);
    repeat (n) send_word(gen_item(mode));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bbd_pkg::IDX_BITS-1:0] idx,
                           logic [bbd_pkg::CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bbd_pkg::REG_EDGE_PERIOD:  per_q     = data[bbd_pkg::PERIOD_BITS-1:0];
      bbd_pkg::REG_BLINK_MARGIN: mar_q     = data[bbd_pkg::PERIOD_BITS-1:0];
      bbd_pkg::REG_MAX_ATTEMPTS: att_max_q = data[bbd_pkg::ATT_BITS-1:0];
      bbd_pkg::REG_FAIL_TIMEOUT: tout_q    = data[bbd_pkg::TOUT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) check_word(result);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_OFF;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 12);
      end
    end
  end

  initial begin
    int                              guard;
    logic [bbd_pkg::PERIOD_BITS-1:0] p;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= bbd_pkg::REG_EDGE_PERIOD;
    cfg_data   <= '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    per_q      = bbd_pkg::RST_EDGE_PERIOD;
    mar_q      = bbd_pkg::RST_BLINK_MARGIN;
    att_max_q  = bbd_pkg::RST_MAX_ATTEMPTS;
    tout_q     = bbd_pkg::RST_FAIL_TIMEOUT;
    ph_q       = bbd_pkg::PH_START;
    att_q      = '0;
    edge_q     = '0;
    fail_q     = '0;

    // reset defaults: window is (62500, 437500) around each edge
    dir_table = '{
      row(32'd0, 1'b0, 1'b0, 1'b1, '{bbd_pkg::PH_SEARCH, 1'b0, 1'b0, 1'b0, 1'b0, 3'd1}),
      row(32'd1000, 1'b1, 1'b0, 1'b1, '{bbd_pkg::PH_B1_OFF, 1'b0, 1'b0, 1'b0, 1'b1, 3'd1}),
      row(32'd50000, 1'b0, 1'b1, 1'b1, '{bbd_pkg::PH_RESTART, 1'b0, 1'b0, 1'b0, 1'b0, 3'd1}),
      row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
          '{bbd_pkg::PH_B1_OFF, 1'b0, 1'b0, 1'b0, 1'b1, 3'd2}),
      row(32'd249999,     1'b0, 1'b1),  // time wraps across the edge
      row(32'd300000,     1'b0, 1'b0),  // flag clear below window: hold
      row(32'd312500,     1'b1, 1'b0),  // just above lower bound
      row(32'd749999,     1'b1, 1'b1),  // just below upper bound, both flags
      row(32'd999999,     1'b1, 1'b0),
      row(32'd1249999,    1'b0, 1'b1),
      row(32'd1499999,    1'b1, 1'b0),
      row(32'd1749999,    1'b0, 1'b1),  // fourth off clears attempts
      row(32'd1999999,    1'b1, 1'b0),
      row(32'd2249999,    1'b0, 1'b1),
      row(32'd2499999,    1'b1, 1'b0),
      row(32'd2749999,    1'b0, 1'b1),  // calib folds into sixth off
      row(32'd3500000,    1'b0, 1'b0),  // late, no flag: restart
      row(32'd3500001,    1'b0, 1'b1),
      row(32'd3600000,    1'b1, 1'b1)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      send_word(dir_table[i].word, dir_table[i].fixed_want, dir_table[i].want);

    wait_drained();
    write_reg(bbd_pkg::REG_MAX_ATTEMPTS, {29'($urandom), 3'd7});
    write_reg(bbd_pkg::REG_FAIL_TIMEOUT, 32'd2000000);
    run_frames(100, GEN_SHAPED);
    hold_req = 1'b1;
    run_frames(200, GEN_SHAPED);

    wait_drained();
    write_reg(bbd_pkg::REG_EDGE_PERIOD, 32'hFFFF_FFFF);
    write_reg(bbd_pkg::REG_BLINK_MARGIN, 32'h00FF_FFFF);
    run_frames(200, GEN_SHAPED);

    wait_drained();
    write_reg(bbd_pkg::REG_EDGE_PERIOD, 32'h0);
    write_reg(bbd_pkg::REG_BLINK_MARGIN, 32'hFF00_0000);
    run_frames(100, GEN_SHAPED);

    wait_drained();
    write_reg(bbd_pkg::REG_EDGE_PERIOD, 32'd100);
    write_reg(bbd_pkg::REG_BLINK_MARGIN, 32'd500);
    calm = 1'b1;
    run_frames(150, GEN_SHAPED);
    calm = 1'b0;
    run_frames(50, GEN_SHAPED);

    repeat (5) begin
      wait_drained();
      p = 24'($urandom_range(5000, 1));
      write_reg(bbd_pkg::REG_EDGE_PERIOD, {8'($urandom), p});
      write_reg(bbd_pkg::REG_BLINK_MARGIN, {8'($urandom), 24'($urandom_range(32'(p), 0))});
      run_frames(70, GEN_SHAPED);
    end

    // found and delete are both terminal, so the run ends on the failure path
    wait_drained();
    write_reg(bbd_pkg::REG_MAX_ATTEMPTS, {29'($urandom), 3'd0});
    write_reg(bbd_pkg::REG_FAIL_TIMEOUT, 32'hFFFF_FFFF);
    run_frames(40, GEN_FAIL);
    wait_drained();
    write_reg(bbd_pkg::REG_FAIL_TIMEOUT, 32'd0);
    run_frames(40, GEN_FAIL);

    item_valid <= 1'b0;
    guard = 0;
    while (due_words.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("tb_blink_beacon_detector: PASS");
    end else begin
      $display("tb_blink_beacon_detector: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bbd_pkg.sv
rtl/core/bbd_step.sv
rtl/core/blink_beacon_detector.sv
tb/tb_blink_beacon_detector.sv
